// ===== rtl/bpt_pkg.sv =====
// Shared types, constants and helpers for the barometer compensation pipeline.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package bpt_pkg;

    localparam int CAL_W      = 48;
    localparam int RAW_W      = 20;
    localparam int TEMP_W     = 32;
    localparam int PA_W       = 24;
    localparam int IDX_W      = 8;
    localparam int DVS_W      = 31;
    localparam int DIV_STEPS  = 64;
    localparam int FRONT_LAT  = 9;
    localparam int POST_LAT   = 5;

    localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
    localparam logic        [20:0] P_BASE      = 21'd1048576;
    localparam logic signed [12:0] P_SCALE     = 13'sd3125;
    localparam logic signed [31:0] T_ROUND     = 32'sd128;
    localparam logic signed [63:0] C_BIAS      = 64'sh0000_8000_0000_0000;

    typedef enum logic [IDX_W-1:0] {
        CAL_TEMP       = 8'd0,
        CAL_PRESS_LOW  = 8'd1,
        CAL_PRESS_MID  = 8'd2,
        CAL_PRESS_HIGH = 8'd3
    } cal_index_t;

    typedef struct packed {
        logic [CAL_W-1:0] t_cal;
        logic [CAL_W-1:0] p_low;
        logic [CAL_W-1:0] p_mid;
        logic [CAL_W-1:0] p_high;
    } cal_regs_t;

    // Values that ride alongside the pressure math until the output.
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     invalid;
    } bpt_side_t;

    function automatic logic signed [15:0] cal_s16(input logic [CAL_W-1:0] r,
                                                   input logic [1:0] pos);
        return $signed(r[16*pos +: 16]);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bpt_front.sv =====
// Temperature math and pressure divisor/dividend preparation, nine register stages.
// Depends on bpt_pkg.
`default_nettype none

module bpt_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [bpt_pkg::RAW_W-1:0]     raw_p,
    input  wire logic [bpt_pkg::RAW_W-1:0]     raw_t,
    input  wire bpt_pkg::cal_regs_t            cal,
    output logic                               out_valid,
    output logic signed [63:0]                 num,
    output logic signed [bpt_pkg::DVS_W-1:0]   dvs,
    output bpt_pkg::bpt_side_t                 side
);
    import bpt_pkg::*;

    logic [FRONT_LAT-1:0] vld_reg;

    logic [15:0]        t1_u, p1_u;
    logic signed [15:0] t2_s, t3_s, p2_s, p3_s, p4_s, p5_s, p6_s;

    assign t1_u = cal.t_cal[15:0];
    assign t2_s = cal_s16(cal.t_cal, 2'd1);
    assign t3_s = cal_s16(cal.t_cal, 2'd2);
    assign p1_u = cal.p_low[15:0];
    assign p2_s = cal_s16(cal.p_low, 2'd1);
    assign p3_s = cal_s16(cal.p_low, 2'd2);
    assign p4_s = cal_s16(cal.p_mid, 2'd0);
    assign p5_s = cal_s16(cal.p_mid, 2'd1);
    assign p6_s = cal_s16(cal.p_mid, 2'd2);

    // Raw pressure is carried until stage 8.
    logic [RAW_W-1:0] rp_reg [1:7];

    // Stage 1
    logic signed [17:0] tx;
    logic signed [16:0] td;
    logic signed [33:0] ap, dp;
    logic signed [31:0] a_mul_reg, dd_reg;
    // Stage 2
    logic signed [31:0] a_next, a_reg, dsh;
    logic signed [35:0] bp;
    logic signed [31:0] b_mul_reg;
    // Stage 3
    logic signed [31:0] fine_next, fine_reg;
    // Stage 4
    logic signed [31:0] t5, temp_next;
    logic signed [32:0] v1_next, v1_reg;
    logic signed [TEMP_W-1:0] temp_reg [4:8];
    // Stage 5
    logic signed [65:0] sqf;
    logic signed [48:0] vp5, vp2;
    logic signed [63:0] sq_reg;
    logic signed [48:0] vp5_reg, vp2_reg, vp5b_reg, vp2b_reg;
    // Stage 6
    logic signed [63:0] m6_reg, m3_reg;
    // Stage 7
    logic signed [63:0] v2_next, v1b_next, v2_reg, v1b_reg;
    // Stage 8
    logic signed [63:0] cprod, c_reg, pa_next, pa_reg;
    logic        [20:0] pdiff;
    // Stage 9
    logic signed [63:0] num_reg;
    logic signed [DVS_W-1:0] dvs_reg;
    bpt_side_t          side_reg;

    always_comb begin
        tx  = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, t1_u, 1'b0});
        td  = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, t1_u});
        ap  = tx * t2_s;
        dp  = td * td;

        a_next = a_mul_reg >>> 11;
        dsh    = dd_reg >>> 12;
        bp     = $signed(dsh[19:0]) * t3_s;

        fine_next = a_reg + (b_mul_reg >>> 14);

        t5        = fine_reg + (fine_reg <<< 2) + T_ROUND;
        temp_next = t5 >>> 8;
        v1_next   = $signed({fine_reg[31], fine_reg}) - FINE_OFFSET;

        sqf = v1_reg * v1_reg;
        vp5 = v1_reg * p5_s;
        vp2 = v1_reg * p2_s;

        v2_next  = m6_reg + $signed({vp5b_reg[46:0], 17'b0})
                 + $signed({{13{p4_s[15]}}, p4_s, 35'b0});
        v1b_next = (m3_reg >>> 8) + $signed({{3{vp2b_reg[48]}}, vp2b_reg, 12'b0});

        cprod   = (v1b_reg + C_BIAS) * $signed({1'b0, p1_u});
        pdiff   = P_BASE - {1'b0, rp_reg[7]};
        pa_next = $signed({12'b0, pdiff, 31'b0}) - v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rp_reg[1]   <= raw_p;
            for (int i = 2; i <= 7; i++) rp_reg[i] <= rp_reg[i-1];
            a_mul_reg   <= ap[31:0];
            dd_reg      <= dp[31:0];
            a_reg       <= a_next;
            b_mul_reg   <= bp[31:0];
            fine_reg    <= fine_next;
            temp_reg[4] <= temp_next;
            for (int i = 5; i <= 8; i++) temp_reg[i] <= temp_reg[i-1];
            v1_reg      <= v1_next;
            sq_reg      <= sqf[63:0];
            vp5_reg     <= vp5;
            vp2_reg     <= vp2;
            m6_reg      <= sq_reg * p6_s;
            m3_reg      <= sq_reg * p3_s;
            vp5b_reg    <= vp5_reg;
            vp2b_reg    <= vp2_reg;
            v2_reg      <= v2_next;
            v1b_reg     <= v1b_next;
            c_reg       <= cprod;
            pa_reg      <= pa_next;
            num_reg     <= pa_reg * P_SCALE;
            dvs_reg     <= $signed(c_reg[63:33]);
            side_reg.temp    <= temp_reg[8];
            side_reg.invalid <= (c_reg[63:33] == '0);
        end
    end

    assign out_valid = vld_reg[FRONT_LAT-1];
    assign num       = num_reg;
    assign dvs       = dvs_reg;
    assign side      = side_reg;

endmodule

`default_nettype wire

// ===== rtl/bpt_div.sv =====
// Pipelined signed 64 by 31-bit restoring divider, one quotient bit per stage.
// Depends on bpt_pkg.
`default_nettype none

module bpt_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [63:0]            num,
    input  wire logic signed [bpt_pkg::DVS_W-1:0] dvs,
    input  wire bpt_pkg::bpt_side_t            side_in,
    output logic                               out_valid,
    output logic signed [63:0]                 quot,
    output bpt_pkg::bpt_side_t                 side_out
);
    import bpt_pkg::*;

    logic [DIV_STEPS:0]     vld_reg;
    logic [63:0]            nq_reg   [0:DIV_STEPS];
    logic [DVS_W-1:0]       rem_reg  [0:DIV_STEPS];
    logic [DVS_W-1:0]       md_reg   [0:DIV_STEPS];
    logic                   neg_reg  [0:DIV_STEPS];
    bpt_side_t              side_reg [0:DIV_STEPS];
    logic                   out_vld_reg;
    logic signed [63:0]     q_reg;
    bpt_side_t              qside_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[DIV_STEPS-1:0], in_valid};
            out_vld_reg <= vld_reg[DIV_STEPS];
        end
    end

    // Setup: work on magnitudes, remember the quotient sign.
    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg[0]   <= num[63] ? 64'd0 - num : num;
            md_reg[0]   <= dvs[DVS_W-1] ? '0 - dvs : dvs;
            rem_reg[0]  <= '0;
            neg_reg[0]  <= num[63] ^ dvs[DVS_W-1];
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [DVS_W:0] trial, diff;
        logic           ge;

        always_comb begin
            trial = {rem_reg[k], nq_reg[k][63]};
            diff  = trial - {1'b0, md_reg[k]};
            ge    = (trial >= {1'b0, md_reg[k]});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg[k+1]   <= {nq_reg[k][62:0], ge};
                rem_reg[k+1]  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                md_reg[k+1]   <= md_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg     <= neg_reg[DIV_STEPS] ? $signed(64'd0 - nq_reg[DIV_STEPS])
                                            : $signed(nq_reg[DIV_STEPS]);
            qside_reg <= side_reg[DIV_STEPS];
        end
    end

    assign out_valid = out_vld_reg;
    assign quot      = q_reg;
    assign side_out  = qside_reg;

endmodule

`default_nettype wire

// ===== rtl/bpt_post.sv =====
// Second-order pressure correction after the division, five stages ending in
// the output register. Depends on bpt_pkg.
`default_nettype none

module bpt_post (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic signed [63:0]        quot,
    input  wire bpt_pkg::bpt_side_t        side_in,
    input  wire bpt_pkg::cal_regs_t        cal,
    output logic                           out_valid,
    output logic [bpt_pkg::PA_W-1:0]       pressure_pa,
    output logic signed [bpt_pkg::TEMP_W-1:0] temperature_centi,
    output logic                           pressure_invalid
);
    import bpt_pkg::*;

    logic [POST_LAT-1:0] vld_reg;
    logic signed [15:0]  p7_s, p8_s, p9_s;

    assign p7_s = cal_s16(cal.p_high, 2'd0);
    assign p8_s = cal_s16(cal.p_high, 2'd1);
    assign p9_s = cal_s16(cal.p_high, 2'd2);

    logic signed [63:0] ps;
    logic        [63:0] ll_reg, sq2_reg;
    logic        [31:0] lh_reg;
    logic signed [63:0] w2m_reg [1:3];
    logic signed [63:0] q_reg   [1:3];
    logic signed [63:0] w1m_reg, sum_next, sum_reg, pfin;
    bpt_side_t          side_reg [1:4];
    logic [PA_W-1:0]    pa_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic               inv_reg;

    always_comb begin
        ps       = quot >>> 13;
        sum_next = q_reg[3] + (w1m_reg >>> 25) + (w2m_reg[3] >>> 19);
        pfin     = (sum_reg >>> 8) + $signed({{44{p7_s[15]}}, p7_s, 4'b0});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[POST_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Low 64 bits of ps squared: low*low plus twice the cross term.
            ll_reg      <= ps[31:0] * ps[31:0];
            lh_reg      <= ps[63:32] * ps[31:0];
            w2m_reg[1]  <= quot * p8_s;
            q_reg[1]    <= quot;
            side_reg[1] <= side_in;

            sq2_reg     <= ll_reg + {lh_reg[30:0], 33'b0};
            w1m_reg     <= $signed(sq2_reg) * p9_s;
            for (int i = 2; i <= 3; i++) begin
                w2m_reg[i] <= w2m_reg[i-1];
                q_reg[i]   <= q_reg[i-1];
            end
            for (int i = 2; i <= 4; i++) side_reg[i] <= side_reg[i-1];

            sum_reg     <= sum_next;

            pa_reg      <= side_reg[4].invalid ? '0 : pfin[31:8];
            temp_reg    <= side_reg[4].temp;
            inv_reg     <= side_reg[4].invalid;
        end
    end

    assign out_valid         = vld_reg[POST_LAT-1];
    assign pressure_pa       = pa_reg;
    assign temperature_centi = temp_reg;
    assign pressure_invalid  = inv_reg;

endmodule

`default_nettype wire

// ===== rtl/baro_pressure_temp_compensation_unit.sv =====
// Top level: calibration registers, pipeline stall control and the three
// pipeline sections. Depends on bpt_pkg, bpt_front, bpt_div and bpt_post.
//
//   channel  | ports                                       | direction
//   ---------+---------------------------------------------+----------
//   sample   | s_valid s_ready s_raw_pressure s_raw_temp.. | in
//   result   | m_valid m_ready m_pressure_pa m_temp.. m_.. | out
//   config   | cfg_we cfg_index cfg_wdata                  | in
//
// One sample transfer per cycle unless the output stalls; 80 register stages
// (9 front stages, 66 divider stages, 5 correction stages). The 64-step
// quotient pipeline sets the latency. Reset clears all valid bits and the
// calibration registers. When the output holds an untaken result the whole
// pipeline freezes, so nothing is dropped or repeated.
`default_nettype none

module baro_pressure_temp_compensation_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [bpt_pkg::RAW_W-1:0]     s_raw_pressure,
    input  wire logic [bpt_pkg::RAW_W-1:0]     s_raw_temperature,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [bpt_pkg::PA_W-1:0]           m_pressure_pa,
    output logic signed [bpt_pkg::TEMP_W-1:0]  m_temperature_centi,
    output logic                               m_pressure_invalid,
    input  wire logic                          cfg_we,
    input  wire logic [bpt_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [bpt_pkg::CAL_W-1:0]     cfg_wdata
);
    import bpt_pkg::*;

    cal_regs_t cal_reg;
    logic      pipe_en;

    logic                    f_valid, d_valid;
    logic signed [63:0]      f_num, d_quot;
    logic signed [DVS_W-1:0] f_dvs;
    bpt_side_t               f_side, d_side;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CAL_TEMP:       cal_reg.t_cal  <= cfg_wdata;
                CAL_PRESS_LOW:  cal_reg.p_low  <= cfg_wdata;
                CAL_PRESS_MID:  cal_reg.p_mid  <= cfg_wdata;
                CAL_PRESS_HIGH: cal_reg.p_high <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en;

    bpt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_valid),
        .raw_p     (s_raw_pressure),
        .raw_t     (s_raw_temperature),
        .cal       (cal_reg),
        .out_valid (f_valid),
        .num       (f_num),
        .dvs       (f_dvs),
        .side      (f_side)
    );

    bpt_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (f_valid),
        .num       (f_num),
        .dvs       (f_dvs),
        .side_in   (f_side),
        .out_valid (d_valid),
        .quot      (d_quot),
        .side_out  (d_side)
    );

    bpt_post u_post (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (pipe_en),
        .in_valid          (d_valid),
        .quot              (d_quot),
        .side_in           (d_side),
        .cal               (cal_reg),
        .out_valid         (m_valid),
        .pressure_pa       (m_pressure_pa),
        .temperature_centi (m_temperature_centi),
        .pressure_invalid  (m_pressure_invalid)
    );

endmodule

`default_nettype wire
